FILE: rtl/random_walk_3d_statistics_defines.svh
// Assertion macros shared by the random walk statistics RTL.
`ifndef RANDOM_WALK_3D_STATISTICS_DEFINES_SVH
`define RANDOM_WALK_3D_STATISTICS_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RW3D_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RW3D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rw3d_pkg.sv
// Package with the constants, types and codes of the random walk statistics block.
package rw3d_pkg;

  // Sizing of the walk store and the fixed-point format.
  localparam int MAX_WALKS = 1024;
  localparam int FRAC_BITS = 24;

  localparam int WALK_W     = $clog2(MAX_WALKS + 1);
  localparam int ADDR_W     = $clog2(MAX_WALKS);
  localparam int STEPS_W    = 16;
  localparam int NW_W       = 11;
  localparam int SEED_W     = 32;
  localparam int STATE_W    = 48;
  localparam int POS_W      = 43;
  localparam int DIST_W     = 42;
  localparam int DSUM_W     = 52;
  localparam int DEV_W      = 64;
  localparam int DSQ_W      = 2 * POS_W;
  localparam int DRAW_W     = FRAC_BITS + 2;
  localparam int MAG_W      = FRAC_BITS + 1;
  localparam int SQ_W       = 2 * FRAC_BITS + 2;
  localparam int NORM_W     = FRAC_BITS + 1;
  localparam int DIVD_W     = 2 * FRAC_BITS + 1;
  localparam int DEV_MUL_W  = 48;

  // Shared arithmetic unit operand widths.
  localparam int UA_W  = 96;
  localparam int UB_W  = 64;
  localparam int UQ_W  = 64;
  localparam int CNT_W = 7;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STEPS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_WALKS = 8'd1;
  localparam logic [STEPS_W-1:0]   NUM_STEPS_RESET = 16'd1000;
  localparam logic [NW_W-1:0]      NUM_WALKS_RESET = 11'd2;

  // Linear congruential generator constants.
  localparam int                    LCG_MULT_W = 35;
  localparam logic [LCG_MULT_W-1:0] LCG_MULT   = 35'h5DEECE66D;
  localparam logic [STATE_W-1:0]    LCG_INC    = 48'hB;
  localparam logic [15:0]           LCG_LOW    = 16'h330E;

  // Shared unit operations.
  typedef enum logic [1:0] {
    UOP_MUL,
    UOP_DIV,
    UOP_SQRT
  } uop_t;

  typedef struct packed {
    logic             start;
    uop_t             op;
    logic [CNT_W-1:0] count;
  } ureq_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ustat_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_INIT,
    S_DRAW,
    S_SQ,
    S_NORM,
    S_DIV,
    S_DSQ,
    S_DSQRT,
    S_STORE,
    S_MEAN,
    S_DEV_READ,
    S_DEV_WAIT,
    S_DEV,
    S_VAR,
    S_STD,
    S_FINISH
  } seq_state_t;

endpackage

FILE: rtl/rw3d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rw3d_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rw3d_unit.sv
// Shared bit-serial unit: multiply, restoring divide and integer square root.
module rw3d_unit import rw3d_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  ureq_t           req,
  input  logic [UA_W-1:0] a,
  input  logic [UB_W-1:0] b,
  output ustat_t          stat,
  output logic [UA_W-1:0] result
);

  logic             busy;
  logic             done;
  uop_t             op;
  logic [CNT_W-1:0] cnt;
  logic [UA_W-1:0]  acc;
  logic [UA_W-1:0]  sh;
  logic [UQ_W-1:0]  q;
  logic [UB_W-1:0]  bq;

  logic [UA_W-1:0] mul_sum;
  logic [UA_W-1:0] div_r;
  logic [UA_W-1:0] div_d;
  logic            div_ge;
  logic [UA_W-1:0] sq_r;
  logic [UA_W-1:0] sq_t;
  logic            sq_ge;

  // One step of each operation.
  always_comb begin
    mul_sum = acc + sh;
    div_r   = {acc[UA_W-2:0], sh[UA_W-1]};
    div_d   = {{(UA_W-UB_W){1'b0}}, bq};
    div_ge  = div_r >= div_d;
    sq_r    = {acc[UA_W-3:0], sh[UA_W-1:UA_W-2]};
    sq_t    = {{(UA_W-UQ_W-2){1'b0}}, q, 2'b01};
    sq_ge   = sq_r >= sq_t;
  end

  // Control: iteration count and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= UOP_MUL;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
        op   <= req.op;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: operand load and one iteration per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      bq  <= b;
      case (req.op)
        UOP_MUL: begin
          sh <= {{(UA_W-UB_W){1'b0}}, b};
          q  <= a[UQ_W-1:0];
        end
        default: begin
          sh <= a;
          q  <= '0;
        end
      endcase
    end else if (busy) begin
      case (op)
        UOP_MUL: begin
          if (q[0]) begin
            acc <= mul_sum;
          end
          sh <= sh << 1;
          q  <= q >> 1;
        end
        UOP_DIV: begin
          acc <= div_ge ? div_r - div_d : div_r;
          sh  <= sh << 1;
          q   <= {q[UQ_W-2:0], div_ge};
        end
        default: begin
          acc <= sq_ge ? sq_r - sq_t : sq_r;
          sh  <= sh << 2;
          q   <= {q[UQ_W-2:0], sq_ge};
        end
      endcase
    end
  end

  // Result select.
  always_comb begin
    case (op)
      UOP_MUL: result = acc;
      default: result = {{(UA_W-UQ_W){1'b0}}, q};
    endcase
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: rtl/random_walk_3d_statistics.sv
// Top level of the 3D random walk statistics block: sequencer, registers and store.
//
// A request (start while busy is low) seeds the drand48-style generator and runs
// num_walks walks (clipped to 1024) of num_steps unit steps, then returns the
// mean final distance and the sample standard deviation on one result_valid
// strobe; the receiver cannot stall, so the result must be captured in that
// cycle. All multiplies, divides and square roots go through one bit-serial unit
// that works one bit per cycle, and that unit sets the time: a step takes three
// 35-bit generator products, three squares, a 25-bit root and three 49-bit
// divides, a walk adds three 43-bit squares and a 48-bit root for its distance,
// and the statistics take a 52-bit divide for the mean, a 48-bit square per
// walk, then a 64-bit divide and a 48-bit root. The reset setting is 1000 steps
// and 2 walks. With num_walks below 2 the flag result comes in the cycle after
// the request. Configuration is taken at any time with cfg_ready held high, but
// the registers are read throughout a run, so change them only while busy is low.
`include "random_walk_3d_statistics_defines.svh"

module random_walk_3d_statistics import rw3d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [SEED_W-1:0]     seed,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_valid,
  output logic [DIST_W-1:0]     mean_distance,
  output logic [DIST_W-1:0]     std_deviation,
  output logic                  too_few_walks
);

  seq_state_t state, state_next;

  logic [STEPS_W-1:0] num_steps;
  logic [NW_W-1:0]    num_walks;
  logic               pend;
  logic [1:0]         k;
  logic [STEPS_W-1:0] step_cnt;
  logic [WALK_W-1:0]  walk_cnt;
  logic [STATE_W-1:0] gen;
  logic signed [DRAW_W-1:0] d [3];
  logic signed [POS_W-1:0]  pos [3];
  logic [SQ_W-1:0]      sq_sum;
  logic [NORM_W-1:0]    norm;
  logic [DSQ_W-1:0]     dsq;
  logic [DIST_W-1:0]    walk_dist;
  logic [DSUM_W-1:0]    dist_sum;
  logic [DSUM_W-1:0]    mean;
  logic [DEV_W-1:0]     dev_sum;
  logic [DEV_MUL_W-1:0] diff_mag;
  logic                 diff_big;
  logic [DEV_W-1:0]     var_q;

  ureq_t           u_req;
  ustat_t          u_stat;
  logic [UA_W-1:0] u_a;
  logic [UA_W-1:0] u_res;
  logic [UB_W-1:0] u_b;
  logic            is_op;
  logic            skip;
  logic            adv;

  logic              ram_we;
  logic [DIST_W-1:0] ram_rdata;

  logic [WALK_W-1:0]    n_walks;
  logic                 accept;
  logic                 last_step;
  logic                 last_walk;
  logic signed [DRAW_W-1:0] d_sel;
  logic [MAG_W-1:0]     d_mag;
  logic signed [POS_W-1:0] pos_sel;
  logic [POS_W-1:0]     pos_mag;
  logic [STATE_W-1:0]   gen_new;
  logic signed [DRAW_W-1:0] d_new;
  logic signed [POS_W:0] u_ext;
  logic signed [POS_W:0] p_sum;
  logic signed [POS_W-1:0] p_sat;
  logic [DSUM_W:0]      dsum_add;
  logic [DSUM_W:0]      diff_s;
  logic [DSUM_W:0]      diff_abs;
  logic [DEV_W-1:0]     term;
  logic [DEV_W:0]       dev_add;
  logic [DIST_W-1:0]    root_sat;

  // Walk count limited to the store depth; step and walk end tests.
  always_comb begin
    if (int'(num_walks) > MAX_WALKS) begin
      n_walks = WALK_W'(MAX_WALKS);
    end else begin
      n_walks = WALK_W'(num_walks);
    end
    accept    = start && (state == S_IDLE);
    last_step = ({1'b0, step_cnt} + 1'b1) == {1'b0, num_steps};
    last_walk = (walk_cnt + 1'b1) == n_walks;
  end

  // Operand selection and result shaping.
  always_comb begin
    d_sel    = d[k];
    d_mag    = d_sel[DRAW_W-1] ? MAG_W'(-d_sel) : MAG_W'(d_sel);
    pos_sel  = pos[k];
    pos_mag  = pos_sel[POS_W-1] ? POS_W'(-pos_sel) : POS_W'(pos_sel);
    gen_new  = u_res[STATE_W-1:0] + LCG_INC;
    d_new    = DRAW_W'({1'b0, gen_new[STATE_W-1 -: MAG_W]}) - (DRAW_W'(1) << FRAC_BITS);
    u_ext    = (POS_W+1)'(u_res[NORM_W-1:0]);
    p_sum    = {pos_sel[POS_W-1], pos_sel} + (d_sel[DRAW_W-1] ? -u_ext : u_ext);
    if (p_sum[POS_W] != p_sum[POS_W-1]) begin
      p_sat = p_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      p_sat = p_sum[POS_W-1:0];
    end
    dsum_add = {1'b0, dist_sum} + (DSUM_W+1)'(walk_dist);
    diff_s   = (DSUM_W+1)'(ram_rdata) - {1'b0, mean};
    diff_abs = diff_s[DSUM_W] ? -diff_s : diff_s;
    if (diff_big || (|u_res[UA_W-1:DEV_W+FRAC_BITS])) begin
      term = '1;
    end else begin
      term = u_res[DEV_W+FRAC_BITS-1:FRAC_BITS];
    end
    dev_add  = {1'b0, dev_sum} + {1'b0, term};
    root_sat = (|u_res[UA_W-1:DIST_W]) ? '1 : u_res[DIST_W-1:0];
  end

  // Sequencer outputs: unit request, operands and store control.
  always_comb begin
    is_op = 1'b1;
    skip  = 1'b0;
    u_req.op    = UOP_MUL;
    u_req.count = '0;
    u_a = '0;
    u_b = '0;
    case (state)
      S_DRAW: begin
        u_req.count = CNT_W'(LCG_MULT_W);
        u_a = UA_W'(LCG_MULT);
        u_b = UB_W'(gen);
      end
      S_SQ: begin
        u_req.count = CNT_W'(MAG_W);
        u_a = UA_W'(d_mag);
        u_b = UB_W'(d_mag);
      end
      S_NORM: begin
        u_req.op    = UOP_SQRT;
        u_req.count = CNT_W'(NORM_W);
        u_a = {sq_sum, {(UA_W-SQ_W){1'b0}}};
      end
      S_DIV: begin
        u_req.op    = UOP_DIV;
        u_req.count = CNT_W'(DIVD_W);
        u_a = {d_mag, {(UA_W-MAG_W){1'b0}}};
        u_b = UB_W'(norm);
      end
      S_DSQ: begin
        u_req.count = CNT_W'(POS_W);
        u_a = UA_W'(pos_mag);
        u_b = UB_W'(pos_mag);
      end
      S_DSQRT: begin
        u_req.op    = UOP_SQRT;
        u_req.count = CNT_W'(UA_W / 2);
        u_a = UA_W'(dsq);
      end
      S_MEAN: begin
        u_req.op    = UOP_DIV;
        u_req.count = CNT_W'(DSUM_W);
        u_a = {dist_sum, {(UA_W-DSUM_W){1'b0}}};
        u_b = UB_W'(n_walks);
      end
      S_DEV: begin
        u_req.count = CNT_W'(DEV_MUL_W);
        u_a  = UA_W'(diff_mag);
        u_b  = UB_W'(diff_mag);
        skip = diff_big;
      end
      S_VAR: begin
        u_req.op    = UOP_DIV;
        u_req.count = CNT_W'(DEV_W);
        u_a = {dev_sum, {(UA_W-DEV_W){1'b0}}};
        u_b = UB_W'(n_walks - 1'b1);
      end
      S_STD: begin
        u_req.op    = UOP_SQRT;
        u_req.count = CNT_W'(UA_W / 2);
        u_a = UA_W'(var_q) << FRAC_BITS;
      end
      default: begin
        is_op = 1'b0;
      end
    endcase
    u_req.start = is_op && !pend && !skip;
    adv    = u_stat.done || ((state == S_DEV) && diff_big);
    ram_we = (state == S_STORE);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (n_walks >= WALK_W'(2))) begin
          state_next = S_WALK_INIT;
        end
      end
      S_WALK_INIT: state_next = (num_steps == '0) ? S_DSQ : S_DRAW;
      S_DRAW: begin
        if (adv && (k == 2'd2)) begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        if (adv && (k == 2'd2)) begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (adv) begin
          if (u_res[NORM_W-1:0] != '0) begin
            state_next = S_DIV;
          end else begin
            state_next = last_step ? S_DSQ : S_DRAW;
          end
        end
      end
      S_DIV: begin
        if (adv && (k == 2'd2)) begin
          state_next = last_step ? S_DSQ : S_DRAW;
        end
      end
      S_DSQ: begin
        if (adv && (k == 2'd2)) begin
          state_next = S_DSQRT;
        end
      end
      S_DSQRT: begin
        if (adv) begin
          state_next = S_STORE;
        end
      end
      S_STORE:    state_next = last_walk ? S_MEAN : S_WALK_INIT;
      S_MEAN: begin
        if (adv) begin
          state_next = S_DEV_READ;
        end
      end
      S_DEV_READ: state_next = S_DEV_WAIT;
      S_DEV_WAIT: state_next = S_DEV;
      S_DEV: begin
        if (adv) begin
          state_next = last_walk ? S_VAR : S_DEV_READ;
        end
      end
      S_VAR: begin
        if (adv) begin
          state_next = S_STD;
        end
      end
      S_STD: begin
        if (adv) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH:   state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Control registers: state, configuration, counters and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pend         <= 1'b0;
      num_steps    <= NUM_STEPS_RESET;
      num_walks    <= NUM_WALKS_RESET;
      k            <= '0;
      step_cnt     <= '0;
      walk_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == S_FINISH) || (accept && (n_walks < WALK_W'(2)));
      if (u_req.start) begin
        pend <= 1'b1;
      end else if (u_stat.done) begin
        pend <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NUM_STEPS: num_steps <= cfg_data;
          CFG_NUM_WALKS: num_walks <= cfg_data[NW_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          walk_cnt <= '0;
        end
        S_WALK_INIT: begin
          k        <= '0;
          step_cnt <= '0;
        end
        S_DRAW, S_SQ, S_DSQ: begin
          if (adv) begin
            k <= (k == 2'd2) ? 2'd0 : k + 1'b1;
          end
        end
        S_NORM: begin
          if (adv && (u_res[NORM_W-1:0] == '0)) begin
            step_cnt <= step_cnt + 1'b1;
          end
        end
        S_DIV: begin
          if (adv) begin
            k <= (k == 2'd2) ? 2'd0 : k + 1'b1;
            if (k == 2'd2) begin
              step_cnt <= step_cnt + 1'b1;
            end
          end
        end
        S_STORE: begin
          walk_cnt <= last_walk ? '0 : walk_cnt + 1'b1;
        end
        S_DEV: begin
          if (adv) begin
            walk_cnt <= last_walk ? '0 : walk_cnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the walk and the statistics.
  always_ff @(posedge clk) begin
    if (accept) begin
      gen      <= {seed, LCG_LOW};
      dist_sum <= '0;
      dev_sum  <= '0;
      if (n_walks < WALK_W'(2)) begin
        mean_distance <= '0;
        std_deviation <= '0;
        too_few_walks <= 1'b1;
      end
    end
    case (state)
      S_WALK_INIT: begin
        pos[0] <= '0;
        pos[1] <= '0;
        pos[2] <= '0;
      end
      S_DRAW: begin
        if (adv) begin
          gen  <= gen_new;
          d[k] <= d_new;
        end
      end
      S_SQ: begin
        if (adv) begin
          sq_sum <= (k == 2'd0) ? u_res[SQ_W-1:0] : sq_sum + u_res[SQ_W-1:0];
        end
      end
      S_NORM: begin
        if (adv) begin
          norm <= u_res[NORM_W-1:0];
        end
      end
      S_DIV: begin
        if (adv) begin
          pos[k] <= p_sat;
        end
      end
      S_DSQ: begin
        if (adv) begin
          dsq <= (k == 2'd0) ? u_res[DSQ_W-1:0] : dsq + u_res[DSQ_W-1:0];
        end
      end
      S_DSQRT: begin
        if (adv) begin
          walk_dist <= root_sat;
        end
      end
      S_STORE: begin
        dist_sum <= dsum_add[DSUM_W] ? '1 : dsum_add[DSUM_W-1:0];
      end
      S_MEAN: begin
        if (adv) begin
          mean <= u_res[DSUM_W-1:0];
        end
      end
      S_DEV_WAIT: begin
        diff_mag <= diff_abs[DEV_MUL_W-1:0];
        diff_big <= |diff_abs[DSUM_W:DEV_MUL_W];
      end
      S_DEV: begin
        if (adv) begin
          dev_sum <= dev_add[DEV_W] ? '1 : dev_add[DEV_W-1:0];
        end
      end
      S_VAR: begin
        if (adv) begin
          var_q <= u_res[DEV_W-1:0];
        end
      end
      S_STD: begin
        if (adv) begin
          mean_distance <= mean[DIST_W-1:0];
          std_deviation <= root_sat;
          too_few_walks <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Shared arithmetic unit.
  rw3d_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .req    (u_req),
    .a      (u_a),
    .b      (u_b),
    .stat   (u_stat),
    .result (u_res)
  );

  // Final distance of each walk, read back in the second pass.
  rw3d_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_WALKS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (walk_cnt[ADDR_W-1:0]),
    .wdata (walk_dist),
    .raddr (walk_cnt[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // The unit is only started when it has finished its previous operation.
  `RW3D_ASSERT_IMPL(a_unit_free_on_start, clk, rst, u_req.start, !u_stat.busy, "unit started while busy")
  // The last state of a run always produces a normal result.
  `RW3D_ASSERT_NEXT(a_finish_result, clk, rst, state == S_FINISH, result_valid && !too_few_walks, "missing result")
  // A request with too few walks answers with the flag in the next cycle.
  `RW3D_ASSERT_NEXT(a_short_request, clk, rst, accept && (n_walks < WALK_W'(2)), result_valid && too_few_walks, "missing flag result")
  // Store writes stay inside the configured walk range.
  `RW3D_ASSERT_IMPL(a_store_in_range, clk, rst, ram_we, walk_cnt < n_walks, "store write out of range")

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the 3D random walk statistics block.
module tb_top;
  import rw3d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Indexes outside the register map; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'hFF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX  = 8'd2;
  localparam logic [DIST_W-1:0]    DIST_MAX = {DIST_W{1'b1}};
  localparam logic [DSUM_W-1:0]    DSUM_MAX = {DSUM_W{1'b1}};
  localparam logic [DEV_W-1:0]     DEV_MAX  = {DEV_W{1'b1}};
  localparam longint               POS_HI   = (64'sd1 <<< (POS_W - 1)) - 1;
  localparam longint               POS_LO   = -(64'sd1 <<< (POS_W - 1));

  typedef enum logic [1:0] {
    REQ_SEED,
    REQ_CFG,
    REQ_DRAIN
  } req_kind_t;

  typedef struct {
    req_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [SEED_W-1:0]      seed;
  } walk_req_t;

  typedef struct {
    logic [DIST_W-1:0] mean;
    logic [DIST_W-1:0] std;
    logic              flag;
  } walk_stats_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [SEED_W-1:0]     seed = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  result_valid;
  logic [DIST_W-1:0]     mean_distance;
  logic [DIST_W-1:0]     std_deviation;
  logic                  too_few_walks;

  walk_req_t   pending_reqs[$];
  walk_stats_t expected_stats[$];
  int          error_count = 0;
  logic        req_taken = 1'b0;

  // Shadow copy of the configuration registers.
  logic [STEPS_W-1:0] steps_per_walk = NUM_STEPS_RESET;
  logic [NW_W-1:0]    walks_per_req  = NUM_WALKS_RESET;

  random_walk_3d_statistics u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .seed(seed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid),
    .mean_distance(mean_distance), .std_deviation(std_deviation),
    .too_few_walks(too_few_walks)
  );

  always #5 clk = ~clk;

  // Floor square root; every root used here is below 2^48.
  function automatic logic [63:0] floor_sqrt(logic [127:0] s);
    logic [63:0]  r;
    logic [127:0] t;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= s) r = t[63:0];
    end
    return r;
  endfunction

  // Mean and sample deviation of the final distances for one seed.
  function automatic walk_stats_t walk_statistics(logic [SEED_W-1:0] s);
    walk_stats_t       res;
    int                n;
    logic [STATE_W-1:0] lcg;
    longint            pos[3];
    longint            d[3];
    longint            p;
    logic [63:0]       m[3];
    logic [63:0]       sq, nrm, u, mean, var_q, term;
    logic [127:0]      wide;
    logic [DIST_W-1:0] walk_dists[];
    logic [DSUM_W:0]   dsum;
    logic [DEV_W:0]    dev_sum;
    longint            diff;
    res = '{mean: '0, std: '0, flag: 1'b0};
    n = (walks_per_req > MAX_WALKS) ? MAX_WALKS : int'(walks_per_req);
    if (n < 2) begin
      res.flag = 1'b1;
      return res;
    end
    walk_dists = new[n];
    lcg = {s, LCG_LOW};
    dsum = '0;
    for (int w = 0; w < n; w++) begin
      pos = '{0, 0, 0};
      for (int st = 0; st < int'(steps_per_walk); st++) begin
        sq = '0;
        for (int k = 0; k < 3; k++) begin
          lcg = lcg * LCG_MULT + LCG_INC;
          d[k] = longint'(lcg >> (47 - FRAC_BITS)) - (64'sd1 <<< FRAC_BITS);
          m[k] = (d[k] < 0) ? -d[k] : d[k];
          sq += m[k] * m[k];
        end
        nrm = floor_sqrt({64'd0, sq});
        // A zero draw vector leaves the position where it is.
        if (nrm != 0) begin
          for (int k = 0; k < 3; k++) begin
            u = (m[k] << FRAC_BITS) / nrm;
            p = pos[k] + ((d[k] < 0) ? -longint'(u) : longint'(u));
            pos[k] = (p > POS_HI) ? POS_HI : ((p < POS_LO) ? POS_LO : p);
          end
        end
      end
      wide = '0;
      for (int k = 0; k < 3; k++) begin
        m[k] = (pos[k] < 0) ? -pos[k] : pos[k];
        wide += {64'd0, m[k]} * {64'd0, m[k]};
      end
      u = floor_sqrt(wide);
      walk_dists[w] = (u > DIST_MAX) ? DIST_MAX : u[DIST_W-1:0];
      dsum += walk_dists[w];
      if (dsum > DSUM_MAX) dsum = DSUM_MAX;
    end
    mean = dsum / n;
    dev_sum = '0;
    for (int w = 0; w < n; w++) begin
      diff = longint'(walk_dists[w]) - longint'(mean);
      m[0] = (diff < 0) ? -diff : diff;
      wide = {64'd0, m[0]} * {64'd0, m[0]};
      term = ((wide >> (64 + FRAC_BITS)) != 0) ? DEV_MAX : wide[FRAC_BITS +: 64];
      dev_sum += term;
      if (dev_sum > DEV_MAX) dev_sum = DEV_MAX;
    end
    var_q = dev_sum[63:0] / (n - 1);
    u = floor_sqrt({64'd0, var_q} << FRAC_BITS);
    res.mean = mean[DIST_W-1:0];
    res.std = (u > DIST_MAX) ? DIST_MAX : u[DIST_W-1:0];
    return res;
  endfunction

  // Monitor: record handshakes, predict on each request and check results.
  always @(posedge clk) begin
    walk_stats_t e;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= (start && !busy) || (cfg_valid && cfg_ready);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NUM_STEPS) steps_per_walk = cfg_data;
        else if (cfg_index == CFG_NUM_WALKS) walks_per_req = cfg_data[NW_W-1:0];
      end
      if (start && !busy) expected_stats.push_back(walk_statistics(seed));
      if (result_valid) begin
        if (expected_stats.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          e = expected_stats.pop_front();
          if (mean_distance !== e.mean) begin
            $error("mean_distance expected %0h actual %0h", e.mean, mean_distance);
            error_count++;
          end
          if (std_deviation !== e.std) begin
            $error("std_deviation expected %0h actual %0h", e.std, std_deviation);
            error_count++;
          end
          if (too_few_walks !== e.flag) begin
            $error("too_few_walks expected %0h actual %0h", e.flag, too_few_walks);
            error_count++;
          end
        end
      end
    end
  end

  // Driver: issues requests in bursts with random gaps between them.
  int burst_left = 1;
  int gap_left = 0;
  logic offering = 1'b0;

  always @(negedge clk) begin
    logic start_n, cfg_n;
    start_n = 1'b0;
    cfg_n = 1'b0;
    if (!rst) begin
      if (offering && req_taken) begin
        void'(pending_reqs.pop_front());
        offering = 1'b0;
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
      if (offering) begin
        start_n = start;
        cfg_n = cfg_valid;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() != 0) begin
        case (pending_reqs[0].kind)
          REQ_SEED: begin
            start_n = 1'b1;
            seed <= pending_reqs[0].seed;
            offering = 1'b1;
          end
          REQ_CFG: begin
            // Registers change only while the block is idle.
            if (expected_stats.size() == 0 && !busy) begin
              cfg_n = 1'b1;
              cfg_index <= pending_reqs[0].idx;
              cfg_data <= pending_reqs[0].data;
              offering = 1'b1;
            end
          end
          default: begin
            if (expected_stats.size() == 0) void'(pending_reqs.pop_front());
          end
        endcase
      end
    end
    start <= start_n;
    cfg_valid <= cfg_n;
  end

  task automatic add_seed(logic [SEED_W-1:0] s);
    pending_reqs.push_back('{kind: REQ_SEED, idx: '0, data: '0, seed: s});
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] v);
    pending_reqs.push_back('{kind: REQ_CFG, idx: i, data: v, seed: '0});
  endtask

  // Stimulus and end of run.
  initial begin
    add_seed(32'h0000_0000);             // reset setting, flag cleared
    add_cfg(CFG_NUM_WALKS, 16'd0);       // too few walks
    add_seed(32'hFFFF_FFFF);
    add_cfg(CFG_NUM_STEPS, 16'hFFFF);    // longest walks, still flagged
    add_cfg(CFG_NUM_WALKS, 16'd1);
    add_seed(32'hA5A5_A5A5);
    add_cfg(CFG_UNUSED_IDX, 16'hFFFF);   // ignored index
    add_cfg(CFG_SPARE_IDX, 16'h0000);
    add_cfg(CFG_NUM_STEPS, 16'd0);       // no steps
    add_cfg(CFG_NUM_WALKS, 16'd2);
    add_seed(32'h5A5A_5A5A);
    add_cfg(CFG_NUM_STEPS, 16'd1);
    add_seed(32'h0000_0001);
    add_seed(32'h8000_0000);
    add_cfg(CFG_NUM_STEPS, 16'd0);
    add_cfg(CFG_NUM_WALKS, 16'd1024);    // full store
    add_seed(32'h1234_5678);
    add_cfg(CFG_NUM_WALKS, 16'h07FF);    // clipped to the store size
    add_seed(32'hDEAD_BEEF);
    add_cfg(CFG_NUM_STEPS, 16'd3);
    add_cfg(CFG_NUM_WALKS, 16'd3);
    add_seed(32'hFFFF_0000);
    pending_reqs.push_back('{kind: REQ_DRAIN, idx: '0, data: '0, seed: '0});
    add_seed(32'h0000_FFFF);
    for (int i = 0; i < 100; i++) begin
      if (i % 10 == 0) begin
        add_cfg(CFG_NUM_STEPS, CFG_DATA_W'($urandom_range(0, 6)));
        add_cfg(CFG_NUM_WALKS, CFG_DATA_W'(($urandom_range(0, 5) == 0) ?
                                           $urandom_range(0, 1) : $urandom_range(2, 6)));
      end
      if (i == 50)
        pending_reqs.push_back('{kind: REQ_DRAIN, idx: '0, data: '0, seed: '0});
      add_seed($urandom);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || expected_stats.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog against a hung block.
  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: random_walk_3d_statistics.f
+incdir+rtl
rtl/rw3d_pkg.sv
rtl/rw3d_ram.sv
rtl/rw3d_unit.sv
rtl/random_walk_3d_statistics.sv
sim/tb_top.sv
